// ===== rtl/lnb_pkg.sv =====
// Shared definitions for the character display nibble-bus register block.
// Holds register offsets, control bit positions, field widths and bus codes.
// No dependencies.
package lnb_pkg;

   localparam int unsigned ByteW    = 8;
   localparam int unsigned NibW     = 4;
   localparam int unsigned AddrW    = 3;
   localparam int unsigned WakeW    = 2;
   localparam int unsigned ReqDataW = 16;
   localparam int unsigned RspDataW = 24;
   localparam int unsigned RspUserW = 2;

   typedef enum logic [AddrW-1:0] {
      REG_LIGHT    = 3'd0,
      REG_DATA     = 3'd1,
      REG_CONTROL  = 3'd2,
      REG_DATA_DIR = 3'd3,
      REG_CTRL_DIR = 3'd4
   } reg_addr_type;

   localparam logic OP_READ  = 1'b0;
   localparam logic OP_WRITE = 1'b1;

   localparam int unsigned CtlRsBit = 0;
   localparam int unsigned CtlRwBit = 1;
   localparam int unsigned CtlEnBit = 2;

   localparam logic [NibW-1:0]  WakeNibble = 4'h3;
   localparam logic [WakeW-1:0] WakeFull   = 2'd3;
   localparam logic [2:0]       FuncSetTop = 3'b001;
   localparam int unsigned      FuncSetDlBit = 4;

   typedef struct packed {
      logic             valid;
      logic             select;
      logic [ByteW-1:0] value;
   } panel_out_type;

endpackage

// ===== rtl/lcd_nibble_bus_register_block_unit.sv =====
// Character display nibble-bus register block, top level.
// Depends on lnb_pkg for offsets, control bits, widths and the panel output struct.
//
// Usage:
//   The req_ channel carries one bus access per transaction: req_tuser is the
//   access kind (write when high), req_tdata the offset and the write byte.
//   Every access yields exactly one rsp_ transaction with the read-back byte,
//   any byte completed for the panel with its select bit, and the backlight
//   value after the access.
//   The response is registered and appears in the cycle after the request is
//   accepted. One access per cycle while rsp_tready is high; the register
//   state and the output register update in the same cycle as acceptance.
//   req_tready is high whenever the output register is empty or is being
//   taken in the same cycle, so a stalled receiver holds the response and
//   blocks new requests only while it stalls.
//   Reset (synchronous, active high) clears all state registers, empties the
//   output register and selects eight-bit mode.
module lcd_nibble_bus_register_block_unit (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_tvalid,
   output logic                         req_tready,
   input  logic [lnb_pkg::ReqDataW-1:0] req_tdata,  // reg_addr[2:0], write_data[10:3], zero pad
   input  logic                         req_tuser,  // op
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   output logic [lnb_pkg::RspDataW-1:0] rsp_tdata,  // read_data, panel_byte, backlight_level
   output logic [lnb_pkg::RspUserW-1:0] rsp_tuser   // byte_valid, byte_select
);
   import lnb_pkg::*;

   logic [ByteW-1:0] data_ff, data_in;
   logic [ByteW-1:0] ctrl_ff, ctrl_in;
   logic [ByteW-1:0] ddir_ff, ddir_in;
   logic [ByteW-1:0] cdir_ff, cdir_in;
   logic [ByteW-1:0] light_ff, light_in;
   logic             wide_ff, wide_in;
   logic             lowpend_ff, lowpend_in;
   logic [NibW-1:0]  hinib_ff, hinib_in;
   logic             hsel_ff, hsel_in;
   logic [WakeW-1:0] wake_ff, wake_in;

   logic             rvalid_ff, rvalid_in;
   logic [ByteW-1:0] rdata_ff, rdata_in;
   panel_out_type    panel_ff, panel_in;
   logic [ByteW-1:0] rlight_ff;

   logic             accept;
   logic             op;
   reg_addr_type     addr;
   logic [ByteW-1:0] wdata;
   logic [NibW-1:0]  nib;
   logic             sel;
   logic [ByteW-1:0] emit_byte;
   logic             emit;
   logic             emit_sel;

   assign req_tready = !rvalid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign op         = req_tuser;
   assign addr       = reg_addr_type'(req_tdata[AddrW-1:0]);
   assign wdata      = req_tdata[AddrW +: ByteW];
   assign nib        = data_ff[ByteW-1 -: NibW];
   assign sel        = wdata[CtlRsBit];

   always_comb begin
      data_in    = data_ff;
      ctrl_in    = ctrl_ff;
      ddir_in    = ddir_ff;
      cdir_in    = cdir_ff;
      light_in   = light_ff;
      wide_in    = wide_ff;
      lowpend_in = lowpend_ff;
      hinib_in   = hinib_ff;
      hsel_in    = hsel_ff;
      wake_in    = wake_ff;
      rdata_in   = '0;
      emit       = 1'b0;
      emit_sel   = 1'b0;
      emit_byte  = '0;
      if (op == OP_WRITE) begin
         unique case (addr)
            REG_LIGHT:    light_in = wdata;
            REG_DATA:     data_in  = wdata;
            REG_CONTROL:  ctrl_in  = wdata;
            REG_DATA_DIR: ddir_in  = wdata;
            REG_CTRL_DIR: cdir_in  = wdata;
            default: ;
         endcase
         if (addr == REG_CONTROL && !ctrl_ff[CtlEnBit] && wdata[CtlEnBit]) begin
            if (wdata[CtlRwBit]) begin
               lowpend_in = 1'b0;
            end else begin
               if (!sel && nib == WakeNibble) begin
                  if (wake_ff != WakeFull) begin
                     wake_in = wake_ff + WakeW'(1);
                  end
                  if (wake_in == WakeFull) begin
                     wide_in    = 1'b1;
                     lowpend_in = 1'b0;
                  end
               end else begin
                  wake_in = '0;
               end
               if (wide_in) begin
                  if (!sel) begin
                     emit      = 1'b1;
                     emit_sel  = 1'b0;
                     emit_byte = {nib, {NibW{1'b0}}};
                  end
               end else if (!lowpend_in) begin
                  hinib_in   = nib;
                  hsel_in    = sel;
                  lowpend_in = 1'b1;
               end else begin
                  lowpend_in = 1'b0;
                  emit       = 1'b1;
                  emit_sel   = hsel_ff;
                  emit_byte  = {hinib_ff, nib};
               end
               if (emit && !emit_sel && emit_byte[ByteW-1 -: 3] == FuncSetTop) begin
                  wide_in    = emit_byte[FuncSetDlBit];
                  lowpend_in = 1'b0;
               end
            end
         end
      end else begin
         unique case (addr)
            REG_LIGHT:    rdata_in = light_ff;
            REG_DATA:     rdata_in = data_ff;
            REG_CONTROL:  rdata_in = ctrl_ff;
            REG_DATA_DIR: rdata_in = ddir_ff;
            REG_CTRL_DIR: rdata_in = cdir_ff;
            default:      rdata_in = '0;
         endcase
      end
      panel_in.valid  = emit;
      panel_in.select = emit_sel;
      panel_in.value  = emit_byte;
      rvalid_in       = accept || (rvalid_ff && !rsp_tready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         data_ff    <= '0;
         ctrl_ff    <= '0;
         ddir_ff    <= '0;
         cdir_ff    <= '0;
         light_ff   <= '0;
         wide_ff    <= 1'b1;
         lowpend_ff <= 1'b0;
         hinib_ff   <= '0;
         hsel_ff    <= 1'b0;
         wake_ff    <= '0;
         rvalid_ff  <= 1'b0;
      end else begin
         rvalid_ff <= rvalid_in;
         if (accept) begin
            data_ff    <= data_in;
            ctrl_ff    <= ctrl_in;
            ddir_ff    <= ddir_in;
            cdir_ff    <= cdir_in;
            light_ff   <= light_in;
            wide_ff    <= wide_in;
            lowpend_ff <= lowpend_in;
            hinib_ff   <= hinib_in;
            hsel_ff    <= hsel_in;
            wake_ff    <= wake_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rdata_ff  <= rdata_in;
         panel_ff  <= panel_in;
         rlight_ff <= light_in;
      end
   end

   assign rsp_tvalid = rvalid_ff;
   assign rsp_tdata  = {rlight_ff, panel_ff.value, rdata_ff};
   assign rsp_tuser  = {panel_ff.select, panel_ff.valid};

`ifndef SYNTHESIS
   a_wake_full_wide : assert property (@(posedge clock) disable iff (reset)
      wake_ff == WakeFull |-> wide_ff && !lowpend_ff)
      else $error("wake run full outside wide mode");

   a_select_needs_byte : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[1] |-> rsp_tuser[0])
      else $error("select set without a panel byte");

   a_write_reads_zero : assert property (@(posedge clock) disable iff (reset)
      accept && req_tuser == OP_WRITE |=> rsp_tdata[ByteW-1:0] == '0)
      else $error("write access returned read data");

   a_no_pending_in_wide : assert property (@(posedge clock) disable iff (reset)
      wide_ff |-> !lowpend_ff)
      else $error("nibble pending in wide mode");
`endif

endmodule
